/* src/ip_connect_allowlist_filter_assert.svh */
// Assertion macros for the allowlist filter
`ifndef IP_CONNECT_ALLOWLIST_FILTER_ASSERT_SVH
`define IP_CONNECT_ALLOWLIST_FILTER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define ICAF_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define ICAF_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

/* src/icaf_pkg.sv */
// ----------------------------------------------------------------------------
// icaf_pkg
// Types, codes and constants for the connection allowlist filter.
// ----------------------------------------------------------------------------
package icaf_pkg;

    localparam int V4_PREFIX_ENTRIES_DEF = 4096;
    localparam int V6_PREFIX_ENTRIES_DEF = 4096;
    localparam int RESOLVER_ENTRIES_DEF  = 16;

    localparam logic [7:0]  LOOPBACK_OCTET = 8'd127;
    localparam logic [15:0] DNS_PORT       = 16'd53;
    localparam logic [31:0] MAPPED_MARK    = 32'h0000ffff;
    localparam logic [7:0]  V4_BITS        = 8'd32;
    localparam logic [7:0]  V6_BITS        = 8'd128;

    typedef enum logic [2:0] {
        FUNC_CHECK  = 3'd0,
        FUNC_WR_V4P = 3'd1,
        FUNC_WR_V6P = 3'd2,
        FUNC_WR_V4R = 3'd3,
        FUNC_WR_V6R = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        RULE_DENY     = 3'd0,
        RULE_LOOPBACK = 3'd1,
        RULE_OPEN_DNS = 3'd2,
        RULE_RESOLVER = 3'd3,
        RULE_PREFIX   = 3'd4,
        RULE_ACK      = 3'd5
    } rule_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RES,
        ST_PFX,
        ST_PFX_CMP,
        ST_DONE
    } state_t;

    // leading-ones mask of len bits in a 64-bit word, len 0..64
    function automatic logic [63:0] lead_mask64(input logic [7:0] len);
        logic [63:0] m;
        m = '0;
        if (len >= 8'd64) m = '1;
        else if (len != 8'd0) m = ~(64'hffff_ffff_ffff_ffff >> len[5:0]);
        return m;
    endfunction

endpackage

/* src/icaf_if.sv */
// ----------------------------------------------------------------------------
// icaf_in_if / icaf_out_if
// Valid/ready channels for check and write words and for verdict words.
// ----------------------------------------------------------------------------
interface icaf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [15:0] dest_port;
    logic [11:0] entry_index;
    logic        entry_valid;
    logic [7:0]  prefix_len;
    modport source (output valid, func, is_ipv6, address_high, address_low,
                    dest_port, entry_index, entry_valid, prefix_len, input ready);
    modport sink (input valid, func, is_ipv6, address_high, address_low,
                  dest_port, entry_index, entry_valid, prefix_len, output ready);
endinterface

interface icaf_out_if;
    logic       valid;
    logic       ready;
    logic       allow;
    logic [2:0] verdict_rule;
    modport source (output valid, allow, verdict_rule, input ready);
    modport sink (input valid, allow, verdict_rule, output ready);
endinterface

/* src/ip_connect_allowlist_filter.sv */
// ----------------------------------------------------------------------------
// ip_connect_allowlist_filter
// Default-deny outbound connection filter with prefix allowlist and resolvers.
// ----------------------------------------------------------------------------
// One word at a time. A write passes through ST_DONE and is then acknowledged
// on the output handshake. A check on loopback, or on the DNS port with open
// DNS on, is decided as it is accepted. Any other DNS-port check first scans
// the resolver table one entry a cycle; a check not yet decided then reads
// the prefix memory entry by entry (registered read in ST_PFX, then one shared
// masked compare in ST_PFX_CMP), stopping at the first hit. After reset the
// prefix valid memory is swept clear, and no word is accepted meanwhile.
module ip_connect_allowlist_filter
    import icaf_pkg::*;
#(
    parameter int V4_PREFIX_ENTRIES = V4_PREFIX_ENTRIES_DEF,
    parameter int V6_PREFIX_ENTRIES = V6_PREFIX_ENTRIES_DEF,
    parameter int RESOLVER_ENTRIES  = RESOLVER_ENTRIES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_wdata,
    icaf_in_if.sink    in_ch,
    icaf_out_if.source out_ch
);
`include "ip_connect_allowlist_filter_assert.svh"

    localparam int MAXP = (V4_PREFIX_ENTRIES > V6_PREFIX_ENTRIES) ?
                          V4_PREFIX_ENTRIES : V6_PREFIX_ENTRIES;
    localparam int V4W  = (V4_PREFIX_ENTRIES > 1) ? $clog2(V4_PREFIX_ENTRIES) : 1;
    localparam int V6W  = (V6_PREFIX_ENTRIES > 1) ? $clog2(V6_PREFIX_ENTRIES) : 1;
    localparam int RW   = (RESOLVER_ENTRIES > 1) ? $clog2(RESOLVER_ENTRIES) : 1;
    localparam int PCW  = $clog2(MAXP + 1);
    localparam int RCW  = $clog2(RESOLVER_ENTRIES + 1);

    // prefix memories
    logic [31:0]  v4_addr_mem [V4_PREFIX_ENTRIES];
    logic [6:0]   v4_meta_mem [V4_PREFIX_ENTRIES];
    logic [63:0]  v6_up_mem   [V6_PREFIX_ENTRIES];
    logic [63:0]  v6_lo_mem   [V6_PREFIX_ENTRIES];
    logic [8:0]   v6_meta_mem [V6_PREFIX_ENTRIES];

    // resolver tables, small, scanned at a counter address
    logic [32:0]  v4r_reg [RESOLVER_ENTRIES];
    logic [63:0]  v6r_up_reg [RESOLVER_ENTRIES];
    logic [63:0]  v6r_lo_reg [RESOLVER_ENTRIES];
    logic [RESOLVER_ENTRIES-1:0] v6r_vld_reg;

    state_t state_reg, state_next;
    logic   dns_reg;
    logic [PCW-1:0] pcnt_reg, pcnt_next;
    logic [RCW-1:0] rcnt_reg, rcnt_next;
    logic   v6_reg;
    logic [63:0] hi_reg, lo_reg;
    logic [2:0]  rule_reg, rule_next;
    logic   out_vld_reg;

    // registered prefix read data
    logic [31:0] rd_v4a_reg;
    logic [6:0]  rd_v4m_reg;
    logic [63:0] rd_v6u_reg, rd_v6l_reg;
    logic [8:0]  rd_v6m_reg;

    logic acc;
    assign acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && !out_vld_reg;
    assign out_ch.valid = out_vld_reg;
    assign out_ch.verdict_rule = rule_reg;
    assign out_ch.allow = (rule_reg >= RULE_LOOPBACK) && (rule_reg <= RULE_PREFIX);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) dns_reg <= 1'b0;
        else if (cfg_we) dns_reg <= cfg_wdata[0];
    end

    // early decode of a check word
    logic [63:0] in_hi, in_lo;
    logic        in_v6, mapped, loop;
    always_comb
    begin
        mapped = in_ch.is_ipv6 && in_ch.address_high == 64'd0 &&
                 in_ch.address_low[63:32] == MAPPED_MARK;
        in_v6 = in_ch.is_ipv6 && !mapped;
        in_hi = in_ch.address_high;
        in_lo = in_ch.address_low;
        if (in_v6) loop = (in_hi == 64'd0) && (in_lo == 64'd1);
        else loop = in_lo[31:24] == LOOPBACK_OCTET;
    end

    // shared compare unit
    logic pfx_hit, res_hit;
    logic [RW-1:0] ridx;
    assign ridx = rcnt_reg[RW-1:0];
    always_comb
    begin
        logic [7:0] l6;
        logic [63:0] mh, ml, m4;
        l6 = rd_v6m_reg[7:0];
        mh = lead_mask64((l6 > 8'd64) ? 8'd64 : l6);
        ml = lead_mask64((l6 > 8'd64) ? l6 - 8'd64 : 8'd0);
        m4 = lead_mask64({2'b00, rd_v4m_reg[5:0]});
        if (v6_reg)
            pfx_hit = rd_v6m_reg[8] && (((rd_v6u_reg ^ hi_reg) & mh) == 64'd0) &&
                      (((rd_v6l_reg ^ lo_reg) & ml) == 64'd0);
        else
            pfx_hit = rd_v4m_reg[6] &&
                      (((rd_v4a_reg ^ lo_reg[31:0]) & m4[63:32]) == 32'd0);
        if (v6_reg)
            res_hit = v6r_vld_reg[ridx] && v6r_up_reg[ridx] == hi_reg &&
                      v6r_lo_reg[ridx] == lo_reg;
        else
            res_hit = v4r_reg[ridx][32] && v4r_reg[ridx][31:0] == lo_reg[31:0];
    end

    logic plast;
    assign plast = v6_reg ? (pcnt_reg == PCW'(V6_PREFIX_ENTRIES))
                          : (pcnt_reg == PCW'(V4_PREFIX_ENTRIES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        pcnt_next = pcnt_reg;
        rcnt_next = rcnt_reg;
        rule_next = rule_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                pcnt_next = pcnt_reg + 1'b1;
                if (pcnt_reg == PCW'(MAXP - 1)) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                pcnt_next = '0;
                rcnt_next = '0;
                if (acc)
                begin
                    state_next = ST_DONE;
                    case (in_ch.func)
                        FUNC_CHECK:
                        begin
                            if (loop) rule_next = RULE_LOOPBACK;
                            else if (in_ch.dest_port == DNS_PORT && dns_reg)
                                rule_next = RULE_OPEN_DNS;
                            else if (in_ch.dest_port == DNS_PORT)
                                state_next = ST_RES;
                            else state_next = ST_PFX;
                        end
                        FUNC_WR_V4P, FUNC_WR_V6P, FUNC_WR_V4R, FUNC_WR_V6R:
                            rule_next = RULE_ACK;
                        default: rule_next = RULE_DENY;
                    endcase
                end
            end
            ST_RES:
            begin
                rcnt_next = rcnt_reg + 1'b1;
                if (res_hit)
                begin
                    rule_next = RULE_RESOLVER;
                    state_next = ST_DONE;
                end
                else if (rcnt_reg == RCW'(RESOLVER_ENTRIES - 1))
                    state_next = ST_PFX;
            end
            ST_PFX:
            begin
                if (plast)
                begin
                    rule_next = RULE_DENY;
                    state_next = ST_DONE;
                end
                else state_next = ST_PFX_CMP;
            end
            ST_PFX_CMP:
            begin
                pcnt_next = pcnt_reg + 1'b1;
                if (pfx_hit)
                begin
                    rule_next = RULE_PREFIX;
                    state_next = ST_DONE;
                end
                else state_next = ST_PFX;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pcnt_reg <= '0;
            rcnt_reg <= '0;
            out_vld_reg <= 1'b0;
            v6r_vld_reg <= '0;
            rule_reg <= RULE_DENY;
        end
        else
        begin
            state_reg <= state_next;
            pcnt_reg <= pcnt_next;
            rcnt_reg <= rcnt_next;
            rule_reg <= rule_next;
            if (state_reg == ST_DONE) out_vld_reg <= 1'b1;
            else if (out_ch.ready) out_vld_reg <= 1'b0;
            if (acc && in_ch.func == FUNC_WR_V6R &&
                in_ch.entry_index < 12'(RESOLVER_ENTRIES))
                v6r_vld_reg[in_ch.entry_index[RW-1:0]] <= in_ch.entry_valid;
        end
    end

    // captured check word
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            v6_reg <= in_v6;
            hi_reg <= in_hi;
            lo_reg <= in_lo;
        end
    end

    // resolver writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RESOLVER_ENTRIES; i++) v4r_reg[i][32] <= 1'b0;
        end
        else if (acc && in_ch.func == FUNC_WR_V4R &&
                 in_ch.entry_index < 12'(RESOLVER_ENTRIES))
            v4r_reg[in_ch.entry_index[RW-1:0]] <= {in_ch.entry_valid,
                                                   in_ch.address_low[31:0]};
    end

    always_ff @(posedge clk)
    begin
        if (acc && in_ch.func == FUNC_WR_V6R &&
            in_ch.entry_index < 12'(RESOLVER_ENTRIES))
        begin
            v6r_up_reg[in_ch.entry_index[RW-1:0]] <= in_ch.address_high;
            v6r_lo_reg[in_ch.entry_index[RW-1:0]] <= in_ch.address_low;
        end
    end

    // prefix memories: one write port, one registered read port
    logic [7:0] len4, len6;
    logic [16:0] widx;
    assign len4 = (in_ch.prefix_len > V4_BITS) ? V4_BITS : in_ch.prefix_len;
    assign len6 = (in_ch.prefix_len > V6_BITS) ? V6_BITS : in_ch.prefix_len;
    assign widx = {5'd0, in_ch.entry_index};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            if (pcnt_reg < PCW'(V4_PREFIX_ENTRIES)) v4_meta_mem[pcnt_reg[V4W-1:0]] <= '0;
            if (pcnt_reg < PCW'(V6_PREFIX_ENTRIES)) v6_meta_mem[pcnt_reg[V6W-1:0]] <= '0;
        end
        else if (acc && in_ch.func == FUNC_WR_V4P &&
                 widx < 17'(V4_PREFIX_ENTRIES))
        begin
            v4_addr_mem[widx[V4W-1:0]] <= in_ch.address_low[31:0];
            v4_meta_mem[widx[V4W-1:0]] <= {in_ch.entry_valid, len4[5:0]};
        end
        else if (acc && in_ch.func == FUNC_WR_V6P &&
                 widx < 17'(V6_PREFIX_ENTRIES))
        begin
            v6_up_mem[widx[V6W-1:0]] <= in_ch.address_high;
            v6_lo_mem[widx[V6W-1:0]] <= in_ch.address_low;
            v6_meta_mem[widx[V6W-1:0]] <= {in_ch.entry_valid, len6};
        end
        if (state_reg == ST_PFX)
        begin
            rd_v4a_reg <= v4_addr_mem[pcnt_reg[V4W-1:0]];
            rd_v4m_reg <= v4_meta_mem[pcnt_reg[V4W-1:0]];
            rd_v6u_reg <= v6_up_mem[pcnt_reg[V6W-1:0]];
            rd_v6l_reg <= v6_lo_mem[pcnt_reg[V6W-1:0]];
            rd_v6m_reg <= v6_meta_mem[pcnt_reg[V6W-1:0]];
        end
    end

    // checks
    `ICAF_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_reg != ST_IDLE, !in_ch.ready)
    `ICAF_ASSERT_NEXT(a_done_shows, clk, rst_n, state_reg == ST_DONE, out_vld_reg)
    `ICAF_ASSERT_IMP(a_rcnt_range, clk, rst_n, state_reg == ST_RES,
                     rcnt_reg < RCW'(RESOLVER_ENTRIES))
endmodule

/* tb/sv/icaf_tb_checker.sv */
// ----------------------------------------------------------------------------
// icaf_tb_checker
// Watches the check/write and verdict channels of the allowlist filter, keeps
// its own copy of the tables and the open-DNS register, predicts each verdict
// word and compares it with what the filter returns, oldest first.
// ----------------------------------------------------------------------------
module icaf_tb_checker
    import icaf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_wdata,
    icaf_in_if         in_ch,
    icaf_out_if        out_ch,
    output int         fail_count,
    output int         verdicts_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int V4N  = V4_PREFIX_ENTRIES_DEF;
    localparam int V6N  = V6_PREFIX_ENTRIES_DEF;
    localparam int RESN = RESOLVER_ENTRIES_DEF;

    typedef struct packed {
        logic       allow;
        rule_t      rule;
    } verdict_t;

    // shadow tables
    logic [31:0] v4p_addr [V4N];
    logic [5:0]  v4p_len  [V4N];
    bit          v4p_live [V4N];
    logic [63:0] v6p_hi   [V6N];
    logic [63:0] v6p_lo   [V6N];
    logic [7:0]  v6p_len  [V6N];
    bit          v6p_live [V6N];
    logic [31:0] v4r_addr [RESN];
    bit          v4r_live [RESN];
    logic [63:0] v6r_hi   [RESN];
    logic [63:0] v6r_lo   [RESN];
    bit          v6r_live [RESN];
    bit          open_dns;

    verdict_t verdict_q[$];

    assign verdicts_due = verdict_q.size();

    function automatic logic [63:0] lead_ones(input int unsigned len);
        if (len == 0) return 64'd0;
        if (len >= 64) return '1;
        return ~(64'hffff_ffff_ffff_ffff >> len);
    endfunction

    function automatic rule_t v4_rule(input logic [31:0] a, input logic [15:0] port);
        logic [31:0] m;
        if (a[31:24] == LOOPBACK_OCTET) return RULE_LOOPBACK;
        if (port == DNS_PORT) begin
            if (open_dns) return RULE_OPEN_DNS;
            for (int i = 0; i < RESN; i++)
                if (v4r_live[i] && v4r_addr[i] == a) return RULE_RESOLVER;
        end
        for (int i = 0; i < V4N; i++) begin
            m = 32'(lead_ones(v4p_len[i]) >> 32);
            if (v4p_live[i] && ((v4p_addr[i] ^ a) & m) == 32'd0) return RULE_PREFIX;
        end
        return RULE_DENY;
    endfunction

    function automatic rule_t v6_rule(input logic [63:0] hi, input logic [63:0] lo,
                                      input logic [15:0] port);
        int unsigned len;
        logic [63:0] mh;
        logic [63:0] ml;
        if (hi == 64'd0 && lo == 64'd1) return RULE_LOOPBACK;
        if (hi == 64'd0 && lo[63:32] == MAPPED_MARK) return v4_rule(lo[31:0], port);
        if (port == DNS_PORT) begin
            if (open_dns) return RULE_OPEN_DNS;
            for (int i = 0; i < RESN; i++)
                if (v6r_live[i] && v6r_hi[i] == hi && v6r_lo[i] == lo)
                    return RULE_RESOLVER;
        end
        for (int i = 0; i < V6N; i++) begin
            if (!v6p_live[i]) continue;
            len = v6p_len[i];
            mh = lead_ones(len > 64 ? 64 : len);
            ml = lead_ones(len > 64 ? len - 64 : 0);
            if (((v6p_hi[i] ^ hi) & mh) == 64'd0 && ((v6p_lo[i] ^ lo) & ml) == 64'd0)
                return RULE_PREFIX;
        end
        return RULE_DENY;
    endfunction

    // apply one accepted word to the shadow state, return its verdict
    function automatic verdict_t apply_word();
        verdict_t v;
        int unsigned idx;
        int unsigned len;
        idx = in_ch.entry_index;
        len = in_ch.prefix_len;
        v.rule = RULE_ACK;
        case (in_ch.func)
            FUNC_CHECK:
                v.rule = in_ch.is_ipv6 ?
                    v6_rule(in_ch.address_high, in_ch.address_low, in_ch.dest_port) :
                    v4_rule(in_ch.address_low[31:0], in_ch.dest_port);
            FUNC_WR_V4P:
                if (idx < V4N) begin
                    v4p_addr[idx] = in_ch.address_low[31:0];
                    v4p_len[idx]  = (len > V4_BITS) ? V4_BITS[5:0] : len[5:0];
                    v4p_live[idx] = in_ch.entry_valid;
                end
            FUNC_WR_V6P:
                if (idx < V6N) begin
                    v6p_hi[idx]   = in_ch.address_high;
                    v6p_lo[idx]   = in_ch.address_low;
                    v6p_len[idx]  = (len > V6_BITS) ? V6_BITS : len[7:0];
                    v6p_live[idx] = in_ch.entry_valid;
                end
            FUNC_WR_V4R:
                if (idx < RESN) begin
                    v4r_addr[idx] = in_ch.address_low[31:0];
                    v4r_live[idx] = in_ch.entry_valid;
                end
            FUNC_WR_V6R:
                if (idx < RESN) begin
                    v6r_hi[idx]   = in_ch.address_high;
                    v6r_lo[idx]   = in_ch.address_low;
                    v6r_live[idx] = in_ch.entry_valid;
                end
            default:
                v.rule = RULE_DENY;
        endcase
        v.allow = (v.rule >= RULE_LOOPBACK && v.rule <= RULE_PREFIX);
        return v;
    endfunction

    task automatic report(input string what, input logic [3:0] got, input logic [3:0] want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        open_dns = 1'b0;
        foreach (v4p_live[i]) v4p_live[i] = 1'b0;
        foreach (v6p_live[i]) v6p_live[i] = 1'b0;
        foreach (v4r_live[i]) v4r_live[i] = 1'b0;
        foreach (v6r_live[i]) v6r_live[i] = 1'b0;
    end

    // watch both channels and the register port
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n) begin
            if (cfg_we) open_dns = cfg_wdata[0];
            if (in_ch.valid && in_ch.ready) verdict_q.push_back(apply_word());
            if (out_ch.valid && out_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t ns: verdict word with none expected", $time);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (out_ch.allow !== want.allow)
                        report("allow", {3'd0, out_ch.allow}, {3'd0, want.allow});
                    if (out_ch.verdict_rule !== want.rule)
                        report("verdict_rule", {1'b0, out_ch.verdict_rule},
                               {1'b0, want.rule});
                end
            end
        end
    end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives check and write words into the allowlist filter under varying idle
// and stall rates and open-DNS settings; the checker predicts the verdicts.
// ----------------------------------------------------------------------------
module tb;
    import icaf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // a function code outside the defined set
    localparam logic [2:0] FUNC_BAD = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [0:0] cfg_wdata;
    int         fail_count;
    int         verdicts_due;
    int         idle_pct;
    int         stall_pct;

    logic [31:0] v4_pool [8];
    logic [63:0] v6_pool_hi [8];
    logic [63:0] v6_pool_lo [8];

    icaf_in_if  in_ch();
    icaf_out_if out_ch();

    ip_connect_allowlist_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    icaf_tb_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .fail_count   (fail_count),
        .verdicts_due (verdicts_due)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // receiver stalls
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    // watchdog
    initial
    begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // present one word, wait for edges until the filter shows ready, then return
    task automatic put(input logic [2:0] func, input logic is6, input logic [63:0] hi,
                       input logic [63:0] lo, input logic [15:0] port,
                       input logic [11:0] idx, input logic live, input logic [7:0] len);
        if ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= func;
        in_ch.is_ipv6      <= is6;
        in_ch.address_high <= hi;
        in_ch.address_low  <= lo;
        in_ch.dest_port    <= port;
        in_ch.entry_index  <= idx;
        in_ch.entry_valid  <= live;
        in_ch.prefix_len   <= len;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (verdicts_due != 0);
    endtask

    task automatic set_open_dns(input logic val);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [11:0] pick_index(input int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return 12'($urandom_range(0, span - 1));
        if (r < 8) return 12'($urandom());
        return 12'hfff;
    endfunction

    function automatic logic [7:0] pick_len(input int unsigned top);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 8'd0;
        if (r < 3) return 8'($urandom());
        return 8'($urandom_range(top / 4, top));
    endfunction

    // one random word, mostly checks against and writes from the address pools
    task automatic random_word();
        int unsigned r;
        int unsigned k;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] port;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 7);
        port = ($urandom_range(0, 1) != 0) ? DNS_PORT : 16'($urandom());
        if (r < 12)
            put(FUNC_WR_V4P, 1'($urandom()), rand64(), {$urandom(), v4_pool[k]},
                16'($urandom()), pick_index(8), $urandom_range(0, 3) != 0, pick_len(32));
        else if (r < 24)
            put(FUNC_WR_V6P, 1'($urandom()), v6_pool_hi[k], v6_pool_lo[k],
                16'($urandom()), pick_index(8), $urandom_range(0, 3) != 0, pick_len(128));
        else if (r < 32)
            put(FUNC_WR_V4R, 1'($urandom()), rand64(), {$urandom(), v4_pool[k]},
                16'($urandom()), pick_index(16), $urandom_range(0, 3) != 0,
                8'($urandom()));
        else if (r < 40)
            put(FUNC_WR_V6R, 1'($urandom()), v6_pool_hi[k], v6_pool_lo[k],
                16'($urandom()), pick_index(16), $urandom_range(0, 3) != 0,
                8'($urandom()));
        else if (r < 43)
            put(3'($urandom_range(5, 7)), 1'($urandom()), rand64(), rand64(),
                16'($urandom()), 12'($urandom()), 1'($urandom()), 8'($urandom()));
        else if (r < 70) begin
            lo = {$urandom(), v4_pool[k] ^ (($urandom_range(0, 1) != 0) ? 32'd0 :
                  32'($urandom()) >> $urandom_range(0, 31))};
            if ($urandom_range(0, 9) == 0) lo[31:24] = LOOPBACK_OCTET;
            if ($urandom_range(0, 9) == 0) lo = rand64();
            put(FUNC_CHECK, 1'b0, rand64(), lo, port, 12'($urandom()), 1'($urandom()),
                8'($urandom()));
        end else begin
            hi = v6_pool_hi[k];
            lo = v6_pool_lo[k];
            case ($urandom_range(0, 5))
                0: lo = lo ^ (rand64() >> $urandom_range(0, 63));
                1: hi = hi ^ (rand64() >> $urandom_range(0, 63));
                2: begin hi = 64'd0; lo = {MAPPED_MARK, v4_pool[k]}; end
                3: begin hi = 64'd0; lo = 64'd1; end
                4: begin hi = rand64(); lo = rand64(); end
                default: ;
            endcase
            put(FUNC_CHECK, 1'b1, hi, lo, port, 12'($urandom()), 1'($urandom()),
                8'($urandom()));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_CHECK;
        in_ch.is_ipv6 = 1'b0;
        in_ch.address_high = '0;
        in_ch.address_low = '0;
        in_ch.dest_port = '0;
        in_ch.entry_index = '0;
        in_ch.entry_valid = 1'b0;
        in_ch.prefix_len = '0;
        foreach (v4_pool[i]) begin
            v4_pool[i] = $urandom();
            v6_pool_hi[i] = rand64();
            v6_pool_lo[i] = rand64();
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words
        set_open_dns(1'b0);
        put(FUNC_CHECK, 1'b0, '1, 64'h0000_0000_0a01_0203, 16'd80, '0, 1'b0, '0);
        put(FUNC_WR_V4P, 1'b0, '1, 64'hffff_ffff_0a00_0000, 16'hffff, 12'd0, 1'b1, 8'd8);
        put(FUNC_CHECK, 1'b0, '1, 64'hffff_ffff_0a01_0203, 16'd80, '1, 1'b1, '1);
        put(FUNC_WR_V4P, 1'b0, '0, 64'h0000_0000_c0a8_0101, 16'd0, 12'd1, 1'b1, 8'd200);
        put(FUNC_CHECK, 1'b0, '0, 64'h0000_0000_c0a8_0101, 16'd0, '0, 1'b0, '0);
        put(FUNC_CHECK, 1'b0, '0, 64'h0000_0000_c0a8_0100, 16'd0, '0, 1'b0, '0);
        put(FUNC_WR_V4R, 1'b0, '1, 64'h1234_5678_0808_0808, 16'd0, 12'd15, 1'b1, '0);
        put(FUNC_CHECK, 1'b0, '0, 64'h0000_0000_0808_0808, DNS_PORT, '0, 1'b0, '0);
        put(FUNC_WR_V4R, 1'b0, '0, 64'h0000_0000_0808_0404, 16'd0, 12'd16, 1'b1, '0);
        put(FUNC_CHECK, 1'b1, '0, {MAPPED_MARK, 32'h0808_0808}, DNS_PORT, '0, 1'b0, '0);
        put(FUNC_CHECK, 1'b0, '0, 64'h0000_0000_7f00_0001, 16'd1, '0, 1'b0, '0);
        put(FUNC_CHECK, 1'b1, '0, 64'd1, 16'd1, '0, 1'b0, '0);
        put(FUNC_CHECK, 1'b1, '0, {MAPPED_MARK, 32'h7fff_ffff}, 16'd1, '0, 1'b0, '0);
        put(FUNC_WR_V6R, 1'b0, 64'h2001_4860_4860_0000, 64'h8888, 16'd0, 12'd0, 1'b1, '0);
        put(FUNC_CHECK, 1'b1, 64'h2001_4860_4860_0000, 64'h8888, DNS_PORT, '0, 1'b0, '0);
        put(FUNC_WR_V6P, 1'b0, '1, '1, 16'd0, 12'hfff, 1'b1, 8'd255);
        put(FUNC_CHECK, 1'b1, '1, '1, 16'hffff, '0, 1'b0, '0);
        put(FUNC_WR_V6P, 1'b0, '0, '0, 16'd0, 12'd2, 1'b1, 8'd0);
        put(FUNC_CHECK, 1'b1, 64'h2600_0000_0000_0001, 64'h5, 16'd443, '0, 1'b0, '0);
        put(FUNC_WR_V6P, 1'b0, '0, '0, 16'd0, 12'd2, 1'b0, 8'd0);
        put(FUNC_CHECK, 1'b1, 64'h2600_0000_0000_0001, 64'h5, 16'd443, '0, 1'b0, '0);
        put(FUNC_BAD, 1'b1, '1, '1, '1, '1, 1'b1, '1);
        put(FUNC_WR_V4P, 1'b0, '0, '0, 16'd0, 12'd0, 1'b0, 8'd0);
        set_open_dns(1'b1);
        put(FUNC_CHECK, 1'b0, '0, 64'h0000_0000_0101_0101, DNS_PORT, '0, 1'b0, '0);

        // random phases: free flow, idle sender, stalling receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 76 : (ph == 3) ? 33 : 0;
            stall_pct = (ph == 2) ? 76 : (ph == 3) ? 33 : 0;
            set_open_dns(ph[0]);
            for (int n = 0; n < 30; n++) begin
                // long idle run until everything has drained
                if (ph == 1 && n == 15) drain();
                random_word();
                if (n % 10 == 9 && $urandom_range(0, 1) != 0) begin
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
